[hdl/rpn_pkg.sv]
// Shared constants and types for the RPN stack calculator.
// Used by the ALU, the stack memory and the top level.
package rpn_pkg;
    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int DATA_W = 32;

    localparam logic [2:0] CMD_PUSH = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_DIV  = 3'd4;
    localparam logic [2:0] CMD_DROP = 3'd5;
    localparam logic [2:0] CMD_SWAP = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_SAT       = 3'd3;
    localparam logic [2:0] ST_DIVZERO   = 3'd4;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
        logic              dz;
    } alu_res_t;
endpackage

[hdl/rpn_alu.sv]
// Multi-cycle arithmetic unit: add, subtract, multiply, restoring divide.
// Depends on rpn_pkg.
module rpn_alu
    import rpn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [2:0]        op,
    input  logic [DATA_W-1:0] sec,
    input  logic [DATA_W-1:0] top,
    output logic              done,
    output alu_res_t          res
);
    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_DIV  = 3'd2;
    localparam logic [2:0] A_FIN  = 3'd3;
    localparam logic [2:0] A_DONE = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  op_reg;
    logic        neg_reg;
    logic [31:0] ma_reg, mb_reg;
    logic [63:0] prod_reg;
    logic [48:0] num_reg;
    logic [32:0] rem_reg;
    logic [48:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        dz_reg;
    logic [32:0] sum_reg;
    alu_res_t    res_reg;

    logic [32:0] sa, sb, rsh;
    logic [31:0] mag_s, mag_t;
    logic [48:0] mag_q;
    assign sa = {sec[31], sec};
    assign sb = {top[31], top};
    assign mag_s = sec[31] ? (~sec + 32'd1) : sec;
    assign mag_t = top[31] ? (~top + 32'd1) : top;
    assign rsh = {rem_reg[31:0], num_reg[48]};
    assign mag_q = 49'((prod_reg + 64'h8000) >> 16);

    function automatic alu_res_t sat_mag(input logic [48:0] m, input logic neg);
        alu_res_t r;
        r.dz = 1'b0;
        r.sat = 1'b0;
        if (!neg) begin
            if (m > 49'h7FFFFFFF) begin
                r.sat = 1'b1;
                r.value = 32'h7FFFFFFF;
            end else begin
                r.value = m[31:0];
            end
        end else begin
            if (m > 49'h80000000) begin
                r.sat = 1'b1;
                r.value = 32'h80000000;
            end else begin
                r.value = ~m[31:0] + 32'd1;
            end
        end
        return r;
    endfunction

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            A_IDLE: if (start) begin
                state_next = (op == CMD_MUL) ? A_MUL : (op == CMD_DIV) ? A_DIV : A_FIN;
            end
            A_MUL:  state_next = A_FIN;
            A_DIV:  if (cnt_reg == 6'd48 || dz_reg) state_next = A_FIN;
            A_FIN:  state_next = A_DONE;
            A_DONE: state_next = A_IDLE;
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= A_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            A_IDLE: if (start) begin
                op_reg  <= op;
                neg_reg <= sec[31] ^ top[31];
                ma_reg  <= mag_s;
                mb_reg  <= mag_t;
                num_reg <= {1'b0, mag_s, 16'd0};
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= '0;
                dz_reg  <= (top == 32'd0);
                sum_reg <= (op == CMD_SUB) ? (sa - sb) : (sa + sb);
            end
            A_MUL: prod_reg <= ma_reg * mb_reg;
            A_DIV: begin
                // One quotient bit per cycle, restoring.
                if (rsh >= {1'b0, mb_reg}) begin
                    rem_reg <= rsh - {1'b0, mb_reg};
                    quo_reg <= {quo_reg[47:0], 1'b1};
                end else begin
                    rem_reg <= rsh;
                    quo_reg <= {quo_reg[47:0], 1'b0};
                end
                num_reg <= {num_reg[47:0], 1'b0};
                cnt_reg <= cnt_reg + 6'd1;
            end
            A_FIN: begin
                case (op_reg)
                    CMD_MUL: begin
                        res_reg <= sat_mag(mag_q, neg_reg);
                    end
                    CMD_DIV: begin
                        if (dz_reg) begin
                            res_reg.sat <= 1'b0;
                            res_reg.dz  <= 1'b1;
                            res_reg.value <= (ma_reg == 32'd0) ? 32'd0 :
                                neg_reg ? 32'h80000000 : 32'h7FFFFFFF;
                        end else begin
                            res_reg <= sat_mag(quo_reg + 49'({rem_reg, 1'b0} >= {1'b0, mb_reg}),
                                neg_reg);
                        end
                    end
                    default: begin
                        res_reg.dz <= 1'b0;
                        if (sum_reg[32] != sum_reg[31]) begin
                            res_reg.sat <= 1'b1;
                            res_reg.value <= sum_reg[32] ? 32'h80000000 : 32'h7FFFFFFF;
                        end else begin
                            res_reg.sat <= 1'b0;
                            res_reg.value <= sum_reg[31:0];
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign done = (state_reg == A_DONE);
    assign res  = res_reg;
endmodule

[hdl/rpn_stack_mem.sv]
// Synchronous stack store, one write port and one registered read port.
// Depends on rpn_pkg.
module rpn_stack_mem
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [STACK_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

[hdl/rpn_stack_calculator.sv]
// RPN stack calculator top level: command sequencer around the stack memory and ALU.
// One command at a time; the next is taken once the result register is free. Divide
// time is set by the one-bit-per-cycle divider in the ALU.
// Reset (aresetn low, synchronous) empties the stack; memory contents stay undefined.
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
    localparam int CW = $clog2(STACK_DEPTH + 1)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // req_type[2:0], operand[34:3], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // shown[0], value[32:1], status[35:33], zero fill
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD1  = 3'd1;  // top read issued
    localparam logic [2:0] S_RD2  = 3'd2;  // second read issued, top returns
    localparam logic [2:0] S_EXEC = 3'd3;  // second returns
    localparam logic [2:0] S_ALU  = 3'd4;
    localparam logic [2:0] S_SWP  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [2:0]  cmd_reg;
    logic [31:0] top_reg, sec_reg;
    logic        outv_reg, outv_next;
    logic        shown_reg, shown_next;
    logic [31:0] value_reg, value_next;
    logic [2:0]  status_reg, status_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;
    logic          alu_start, alu_done;
    alu_res_t      alu_res;

    logic [2:0]  in_cmd;
    logic [31:0] in_opnd;
    assign in_cmd  = s_tdata[2:0];
    assign in_opnd = s_tdata[34:3];

    rpn_stack_mem #(.STACK_DEPTH(STACK_DEPTH)) u_mem (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // The second entry is still on the read port when the ALU starts.
    rpn_alu u_alu (
        .aclk(aclk), .aresetn(aresetn), .start(alu_start), .op(cmd_reg),
        .sec(rdata), .top(top_reg), .done(alu_done), .res(alu_res)
    );

    assign s_tready = (state_reg == S_IDLE) && !outv_reg;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        outv_next   = outv_reg;
        shown_next  = shown_reg;
        value_next  = value_reg;
        status_next = status_reg;
        we = 1'b0;
        waddr = AW'(count_reg - CW'(1));
        wdata = top_reg;
        raddr = AW'(count_reg - CW'(1));
        alu_start = 1'b0;
        if (outv_reg && m_tready) outv_next = 1'b0;
        case (state_reg)
            S_IDLE: if (s_tvalid && s_tready) begin
                shown_next = 1'b0;
                value_next = '0;
                status_next = ST_OK;
                case (in_cmd)
                    CMD_PUSH: begin
                        if (count_reg < CW'(STACK_DEPTH)) begin
                            we = 1'b1;
                            waddr = AW'(count_reg);
                            wdata = in_opnd;
                            count_next = count_reg + CW'(1);
                            shown_next = 1'b1;
                            value_next = in_opnd;
                        end else begin
                            status_next = ST_FULL;
                        end
                        outv_next = 1'b1;
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_SWAP: begin
                        if (count_reg < CW'(2)) begin
                            count_next = '0;
                            status_next = ST_UNDERFLOW;
                            outv_next = 1'b1;
                        end else begin
                            state_next = S_RD1;
                        end
                    end
                    CMD_DROP: begin
                        if (count_reg == '0) begin
                            status_next = ST_UNDERFLOW;
                            outv_next = 1'b1;
                        end else begin
                            count_next = count_reg - CW'(1);
                            if (count_reg == CW'(1)) outv_next = 1'b1;
                            else state_next = S_RD2;
                        end
                    end
                    default: outv_next = 1'b1;
                endcase
            end
            S_RD1: begin
                raddr = AW'(count_reg - CW'(1));
                state_next = S_RD2;
            end
            S_RD2: begin
                // Drop reads the new top here; others read the second entry.
                raddr = (cmd_reg == CMD_DROP) ? AW'(count_reg - CW'(1))
                                              : AW'(count_reg - CW'(2));
                state_next = (cmd_reg == CMD_DROP) ? S_OUT : S_EXEC;
            end
            S_EXEC: begin
                if (cmd_reg == CMD_SWAP) begin
                    we = 1'b1;
                    waddr = AW'(count_reg - CW'(2));
                    wdata = top_reg;
                    state_next = S_SWP;
                end else begin
                    alu_start = 1'b1;
                    state_next = S_ALU;
                end
            end
            S_SWP: begin
                we = 1'b1;
                waddr = AW'(count_reg - CW'(1));
                wdata = sec_reg;
                shown_next = 1'b1;
                value_next = sec_reg;
                outv_next = 1'b1;
                state_next = S_IDLE;
            end
            S_ALU: if (alu_done) begin
                we = 1'b1;
                waddr = AW'(count_reg - CW'(2));
                wdata = alu_res.value;
                count_next = count_reg - CW'(1);
                shown_next = 1'b1;
                value_next = alu_res.value;
                status_next = alu_res.dz ? ST_DIVZERO : (alu_res.sat ? ST_SAT : ST_OK);
                outv_next = 1'b1;
                state_next = S_IDLE;
            end
            S_OUT: begin
                shown_next = 1'b1;
                value_next = rdata;
                outv_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            outv_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            outv_reg  <= outv_next;
        end
    end

    always_ff @(posedge aclk) begin
        shown_reg  <= shown_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        if (s_tvalid && s_tready) cmd_reg <= in_cmd;
        if (state_reg == S_RD2) top_reg <= rdata;
        if (state_reg == S_EXEC) sec_reg <= rdata;
    end

    assign m_tvalid = outv_reg;
    assign m_tdata  = {4'd0, status_reg, value_reg, shown_reg};
endmodule

[dv/tb.sv]
// Self-checking testbench for the RPN stack calculator: directed and random command streams.
// Depends on rpn_pkg and rpn_stack_calculator; a scoreboard class tracks the expected words.
module tb;
    import rpn_pkg::*;

    localparam int DEPTH = DEFAULT_STACK_DEPTH;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        shown;
        logic [31:0] value;
        logic [2:0]  status;
    } calc_out_t;

    class calc_scoreboard;
        logic [31:0] stack_mem [DEPTH];
        int          depth_used;
        calc_out_t   pending [$];
        int          mismatches;

        function new();
            depth_used = 0;
            mismatches = 0;
        endfunction

        function logic [31:0] clamp(longint v, inout bit sat);
            if (v > 64'sd2147483647) begin
                sat = 1;
                return 32'h7FFFFFFF;
            end
            if (v < -64'sd2147483648) begin
                sat = 1;
                return 32'h80000000;
            end
            return v[31:0];
        endfunction

        // Magnitude with sign applied, then clamped.
        function logic [31:0] clamp_mag(longint unsigned m, bit neg, inout bit sat);
            if (!neg) begin
                if (m > 64'h7FFFFFFF) begin
                    sat = 1;
                    return 32'h7FFFFFFF;
                end
                return m[31:0];
            end
            if (m > 64'h80000000) begin
                sat = 1;
                return 32'h80000000;
            end
            return 32'(0 - m);
        endfunction

        function void note_command(logic [2:0] cmd, logic [31:0] opnd);
            calc_out_t       r;
            logic [31:0]     tp, sc, res;
            longint          x, y;
            longint unsigned mx, my, m, q, rem;
            bit              sat, dz;
            r = '0;
            r.status = ST_OK;
            sat = 0;
            dz = 0;
            if (cmd == CMD_PUSH) begin
                if (depth_used < DEPTH) begin
                    stack_mem[depth_used] = opnd;
                    depth_used++;
                    r.shown = 1;
                    r.value = opnd;
                end else begin
                    r.status = ST_FULL;
                end
            end else if (cmd >= CMD_ADD && cmd <= CMD_DIV) begin
                if (depth_used < 2) begin
                    depth_used = 0;
                    r.status = ST_UNDERFLOW;
                end else begin
                    tp = stack_mem[depth_used-1];
                    sc = stack_mem[depth_used-2];
                    x = longint'($signed(sc));
                    y = longint'($signed(tp));
                    mx = (x < 0) ? -x : x;
                    my = (y < 0) ? -y : y;
                    case (cmd)
                        CMD_ADD: res = clamp(x + y, sat);
                        CMD_SUB: res = clamp(x - y, sat);
                        CMD_MUL: begin
                            m = (mx * my + 64'h8000) >> 16;
                            res = clamp_mag(m, (x < 0) != (y < 0), sat);
                        end
                        default: begin
                            if (y == 0) begin
                                dz = 1;
                                res = (x > 0) ? 32'h7FFFFFFF : (x < 0) ? 32'h80000000 : 32'h0;
                            end else begin
                                q = (mx << 16) / my;
                                rem = (mx << 16) % my;
                                if (2 * rem >= my) q++;
                                res = clamp_mag(q, (x < 0) != (y < 0), sat);
                            end
                        end
                    endcase
                    depth_used--;
                    stack_mem[depth_used-1] = res;
                    r.shown = 1;
                    r.value = res;
                    r.status = dz ? ST_DIVZERO : (sat ? ST_SAT : ST_OK);
                end
            end else if (cmd == CMD_DROP) begin
                if (depth_used == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    depth_used--;
                    if (depth_used > 0) begin
                        r.shown = 1;
                        r.value = stack_mem[depth_used-1];
                    end
                end
            end else if (cmd == CMD_SWAP) begin
                if (depth_used < 2) begin
                    depth_used = 0;
                    r.status = ST_UNDERFLOW;
                end else begin
                    tp = stack_mem[depth_used-1];
                    stack_mem[depth_used-1] = stack_mem[depth_used-2];
                    stack_mem[depth_used-2] = tp;
                    r.shown = 1;
                    r.value = stack_mem[depth_used-1];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_word(logic [39:0] word);
            calc_out_t got, want;
            // The word carries shown in bit 0, value above it, then status.
            got = {word[0], word[32:1], word[35:33]};
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", word);
                return;
            end
            want = pending.pop_front();
            if (got !== want || word[39:36] !== 4'b0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: shown %b/%b value %h/%h status %0d/%0d",
                             want.shown, got.shown, want.value, got.value,
                             want.status, got.status);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;

    calc_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  sending_done = 0;

    always #5 aclk = ~aclk;

    rpn_stack_calculator dut (.*);

    // Receiver stalls on a pattern of its own: runs of ready, runs of stall.
    int stall_mode = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if ($urandom_range(0, 99) < 3) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_tready <= 1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_word(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("rpn_stack_calculator test failed");
                $finish;
            end
        end
    end

    int burst_left = 0;

    // Valid stays high inside a burst; it drops only for a gap or a drain.
    task automatic send_cmd(logic [2:0] cmd, logic [31:0] opnd);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
            if (gap > 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1;
        s_tdata <= {5'b0, opnd, cmd};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, opnd);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7FFFFFFF;
            2: return 32'h80000000;
            3: return 32'h0;
            4: return {{16{1'b0}}, 16'($urandom())} ^ ({32{$urandom_range(0, 1) == 1}});
            default: return 32'($signed($urandom_range(0, 16)) - 8) << 16;
        endcase
    endfunction

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    initial begin
        logic [2:0] c;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: underflow on an empty stack, each operation, extremes.
        send_cmd(CMD_DROP, 32'hFFFFFFFF);
        send_cmd(CMD_ADD, 0);
        send_cmd(CMD_PUSH, 32'h7FFFFFFF);
        send_cmd(CMD_SWAP, 0);
        send_cmd(CMD_PUSH, 32'h7FFFFFFF);
        send_cmd(CMD_PUSH, 32'h7FFFFFFF);
        send_cmd(CMD_ADD, 0);
        send_cmd(CMD_PUSH, 32'h80000000);
        send_cmd(CMD_SUB, 0);
        send_cmd(CMD_PUSH, 32'h00020000);
        send_cmd(CMD_MUL, 0);
        send_cmd(CMD_PUSH, 0);
        send_cmd(CMD_DIV, 0);
        send_cmd(CMD_PUSH, 32'h80000000);
        send_cmd(CMD_PUSH, 0);
        send_cmd(CMD_DIV, 0);
        send_cmd(CMD_PUSH, 0);
        send_cmd(CMD_PUSH, 0);
        send_cmd(CMD_DIV, 0);
        send_cmd(CMD_PUSH, 32'h00030000);
        send_cmd(CMD_SWAP, 0);
        send_cmd(CMD_DROP, 0);
        send_cmd(3'd7, 32'h12345678);
        send_cmd(CMD_DROP, 0);
        send_cmd(CMD_DROP, 0);
        // Hold off until every expected word has come back.
        drain();

        // Fill the stack past full, then empty it.
        for (int i = 0; i < DEPTH + 2; i++) send_cmd(CMD_PUSH, rand_value());
        for (int i = 0; i < DEPTH + 1; i++) send_cmd(CMD_DROP, 0);

        // Random: mostly well-formed work keeping two or more entries, some noise.
        for (int i = 0; i < 1400; i++) begin
            if (sb.depth_used < 2 || $urandom_range(0, 2) == 0) c = CMD_PUSH;
            else if ($urandom_range(0, 19) == 0) c = 3'($urandom_range(0, 7));
            else c = 3'($urandom_range(1, 6));
            send_cmd(c, (c == CMD_PUSH) ? rand_value() : $urandom());
            if (i == 700) drain();
        end

        drain();
        repeat (100) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("rpn_stack_calculator test passed");
        end else begin
            $display("rpn_stack_calculator test failed");
        end
        $finish;
    end
endmodule
